[rtl/core/hsv2rgb_pkg.sv]
// shared types and constants for the hsv to rgb converter
`default_nettype none

package hsv2rgb_pkg;

	localparam int HUE_W = 13;
	localparam int PCT_W = 7;
	localparam int CHAN_W = 8;

	localparam int PCT_FULL = 100;
	localparam int CHAN_FULL = 255;
	localparam int SECTOR_DEG = 60;
	localparam int NUM_SECTORS = 6;

	// v*s and v*(100-s) products
	localparam int PV_W = $clog2(PCT_FULL * PCT_FULL + 1);
	// sector index before the final mod-6 correction, always below 12
	localparam int REM6_W = 4;

	typedef logic [2:0] sector_t;

	localparam sector_t SEC_RED_YEL = 3'd0;
	localparam sector_t SEC_YEL_GRN = 3'd1;
	localparam sector_t SEC_GRN_CYN = 3'd2;
	localparam sector_t SEC_CYN_BLU = 3'd3;
	localparam sector_t SEC_BLU_MAG = 3'd4;
	localparam sector_t SEC_MAG_RED = 3'd5;

endpackage

`default_nettype wire

[rtl/core/hsv2rgb_if.sv]
// valid/ready channel interfaces for hsv input beats and rgb output beats
`default_nettype none

interface hsv2rgb_in_if import hsv2rgb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [HUE_W-1:0]  hue_offset;
	logic [PCT_W-1:0]  saturation_pct;
	logic [PCT_W-1:0]  value_pct;

	modport source (output valid, output hue_offset, output saturation_pct,
		output value_pct, input ready);
	modport sink (input valid, input hue_offset, input saturation_pct,
		input value_pct, output ready);
endinterface

interface hsv2rgb_out_if import hsv2rgb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, output red, output green, output blue,
		input ready);
	modport sink (input valid, input red, input green, input blue,
		output ready);
endinterface

`default_nettype wire

[rtl/core/hsv2rgb_hue_split.sv]
// stages 1 to 6: hue wrap into sector and offset, channel numerators
`default_nettype none

module hsv2rgb_hue_split import hsv2rgb_pkg::*; #(
	parameter int HUE_STEPS_PER_DEGREE = 16
) (
	input  logic                clk,
	input  logic [6:1]          en,
	input  logic [HUE_W-1:0]    base_hue,
	input  logic [HUE_W-1:0]    hue_offset,
	input  logic [PCT_W-1:0]    saturation_pct,
	input  logic [PCT_W-1:0]    value_pct,
	output logic [REM6_W-1:0]   rem6_s6,
	output logic [$clog2(PCT_FULL*PCT_FULL*SECTOR_DEG*HUE_STEPS_PER_DEGREE+1)-1:0] a_max_s6,
	output logic [$clog2(PCT_FULL*PCT_FULL*SECTOR_DEG*HUE_STEPS_PER_DEGREE+1)-1:0] a_min_s6,
	output logic [$clog2(PCT_FULL*PCT_FULL*SECTOR_DEG*HUE_STEPS_PER_DEGREE+1)-1:0] a_up_s6,
	output logic [$clog2(PCT_FULL*PCT_FULL*SECTOR_DEG*HUE_STEPS_PER_DEGREE+1)-1:0] a_dn_s6
);

	localparam int W = SECTOR_DEG * HUE_STEPS_PER_DEGREE;
	localparam int W_W = $clog2(W + 1);
	localparam int A_W = $clog2(PCT_FULL * PCT_FULL * W + 1);
	localparam int SUM_W = HUE_W + 1;
	localparam int QMAX = ((1 << SUM_W) - 1) / W;
	localparam int Q_W = $clog2(QMAX + 1);
	localparam int K1 = SUM_W + W_W;
	localparam longint unsigned M1 = (longint'(1) << K1) / W;
	localparam int P1_W = SUM_W + K1 + 1;
	localparam int K6 = Q_W + 3;
	localparam longint unsigned M6 = (longint'(1) << K6) / NUM_SECTORS;
	localparam int P6_W = Q_W + K6;

	// stage 1
	logic [PCT_W-1:0] sat_c;
	logic [PCT_W-1:0] val_c;
	logic [SUM_W-1:0] sum_s1;
	logic [PV_W-1:0]  vs_s1;
	logic [PV_W-1:0]  vns_s1;

	// stage 2
	logic [P1_W-1:0]  prod1;
	logic [Q_W-1:0]   qa_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [PV_W-1:0]  vs_s2;
	logic [A_W-1:0]   base_s2;

	// stage 3
	logic [SUM_W-1:0] qw;
	logic [SUM_W-1:0] diff;
	logic [W_W:0]     ra_s3;
	logic [Q_W-1:0]   qa_s3;
	logic [PV_W-1:0]  vs_s3;
	logic [A_W-1:0]   base_s3;

	// stage 4
	logic             wrap;
	logic [W_W-1:0]   f_s4;
	logic [Q_W-1:0]   q_s4;
	logic [PV_W-1:0]  vs_s4;
	logic [A_W-1:0]   base_s4;

	// stage 5
	logic [P6_W-1:0]  prod6;
	logic [W_W-1:0]   f_dn;
	logic [Q_W-1:0]   q6a_s5;
	logic [Q_W-1:0]   q_s5;
	logic [A_W-1:0]   t_up_s5;
	logic [A_W-1:0]   t_dn_s5;
	logic [A_W-1:0]   t_max_s5;
	logic [A_W-1:0]   base_s5;

	// stage 6
	logic [Q_W-1:0]   rem6;

	assign sat_c = (saturation_pct > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : saturation_pct;
	assign val_c = (value_pct > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : value_pct;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sum_s1 <= SUM_W'(base_hue) + SUM_W'(hue_offset);
			vs_s1  <= PV_W'(val_c) * PV_W'(sat_c);
			vns_s1 <= PV_W'(val_c) * PV_W'(PCT_W'(PCT_FULL) - sat_c);
		end
	end

	// sector estimate by reciprocal, may be one low
	assign prod1 = P1_W'(sum_s1) * P1_W'(M1);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			qa_s2   <= prod1[K1 +: Q_W];
			sum_s2  <= sum_s1;
			vs_s2   <= vs_s1;
			base_s2 <= A_W'(vns_s1) * A_W'(W);
		end
	end

	assign qw   = SUM_W'(qa_s2) * SUM_W'(W);
	assign diff = sum_s2 - qw;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ra_s3   <= (W_W + 1)'(diff);
			qa_s3   <= qa_s2;
			vs_s3   <= vs_s2;
			base_s3 <= base_s2;
		end
	end

	assign wrap = (ra_s3 >= (W_W + 1)'(W));

	always_ff @(posedge clk) begin
		if (en[4]) begin
			f_s4    <= wrap ? W_W'(ra_s3 - (W_W + 1)'(W)) : W_W'(ra_s3);
			q_s4    <= qa_s3 + Q_W'(wrap);
			vs_s4   <= vs_s3;
			base_s4 <= base_s3;
		end
	end

	assign prod6 = P6_W'(q_s4) * P6_W'(M6);
	assign f_dn  = W_W'(W) - f_s4;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			q6a_s5   <= prod6[K6 +: Q_W];
			q_s5     <= q_s4;
			t_up_s5  <= A_W'(f_s4) * A_W'(vs_s4);
			t_dn_s5  <= A_W'(f_dn) * A_W'(vs_s4);
			t_max_s5 <= A_W'(vs_s4) * A_W'(W);
			base_s5  <= base_s4;
		end
	end

	assign rem6 = q_s5 - Q_W'(q6a_s5) * Q_W'(NUM_SECTORS);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			rem6_s6  <= REM6_W'(rem6);
			a_max_s6 <= base_s5 + t_max_s5;
			a_min_s6 <= base_s5;
			a_up_s6  <= base_s5 + t_up_s5;
			a_dn_s6  <= base_s5 + t_dn_s5;
		end
	end

endmodule

`default_nettype wire

[rtl/core/hsv2rgb_chan_div.sv]
// stages 7 and 8: channel = floor(255 * a / (10000 * sector width))
`default_nettype none

module hsv2rgb_chan_div import hsv2rgb_pkg::*; #(
	parameter int HUE_STEPS_PER_DEGREE = 16
) (
	input  logic              clk,
	input  logic [1:0]        en,
	input  logic [$clog2(PCT_FULL*PCT_FULL*SECTOR_DEG*HUE_STEPS_PER_DEGREE+1)-1:0] a,
	output logic [CHAN_W-1:0] ch
);

	localparam int W = SECTOR_DEG * HUE_STEPS_PER_DEGREE;
	localparam int D = PCT_FULL * PCT_FULL * W;
	localparam int A_W = $clog2(D + 1);
	localparam int K2 = A_W + CHAN_W;
	localparam longint unsigned R = (longint'(CHAN_FULL) << K2) / D;
	localparam int P2_W = K2 + CHAN_W + 1;
	localparam int X_W = A_W + CHAN_W;
	localparam int RM_W = $clog2(2 * D);

	logic [P2_W-1:0]   prod;
	logic [X_W-1:0]    x255;
	logic [X_W-1:0]    qd;
	logic [CHAN_W-1:0] qp_s7;
	logic [X_W-1:0]    x255_s7;
	logic [CHAN_W-1:0] qp_s8;
	logic [RM_W-1:0]   rem_s8;

	// quotient estimate, at most one low
	assign prod = P2_W'(a) * P2_W'(R);
	assign x255 = (X_W'(a) << CHAN_W) - X_W'(a);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			qp_s7   <= prod[K2 +: CHAN_W];
			x255_s7 <= x255;
		end
	end

	assign qd = X_W'(qp_s7) * X_W'(D);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			qp_s8  <= qp_s7;
			rem_s8 <= RM_W'(x255_s7 - qd);
		end
	end

	assign ch = qp_s8 + CHAN_W'(rem_s8 >= RM_W'(D));

endmodule

`default_nettype wire

[rtl/core/hsv_to_rgb_converter_core.sv]
// hsv to rgb converter top level: hue wrap, sector split, channel division
// throughput: one beat per cycle while rgb.ready is high; each of the 9 register stages holds one item
// stalls collapse empty stages, so input is taken while the output beat waits
// reset: arst_n clears the stage valid bits and base_hue, datapath is not reset
`default_nettype none

module hsv_to_rgb_converter_core import hsv2rgb_pkg::*; #(
	parameter int HUE_STEPS_PER_DEGREE = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [HUE_W-1:0] cfg_wdata,
	hsv2rgb_in_if.sink       hsv,
	hsv2rgb_out_if.source    rgb
);

	localparam int NS = 9;
	localparam int A_W = $clog2(PCT_FULL * PCT_FULL * SECTOR_DEG * HUE_STEPS_PER_DEGREE + 1);

	logic [HUE_W-1:0]  base_hue_q;
	logic [NS:1]       vld_q;
	logic [NS:1]       en;
	logic [NS:1]       vld_in;

	logic [REM6_W-1:0] rem6_s6;
	logic [A_W-1:0]    a_max_s6;
	logic [A_W-1:0]    a_min_s6;
	logic [A_W-1:0]    a_up_s6;
	logic [A_W-1:0]    a_dn_s6;
	sector_t           sector_s7;
	sector_t           sector_s8;

	logic [CHAN_W-1:0] ch_max;
	logic [CHAN_W-1:0] ch_min;
	logic [CHAN_W-1:0] ch_up;
	logic [CHAN_W-1:0] ch_dn;
	logic [CHAN_W-1:0] red_s9;
	logic [CHAN_W-1:0] green_s9;
	logic [CHAN_W-1:0] blue_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_hue_q <= '0;
		end else if (cfg_we) begin
			base_hue_q <= cfg_wdata;
		end
	end

	// a stage moves when it is empty or the next one moves
	always_comb begin
		en[NS] = ~vld_q[NS] | rgb.ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = ~vld_q[k] | en[k + 1];
		end
	end

	assign vld_in = {vld_q[NS-1:1], hsv.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign hsv.ready = en[1];

	hsv2rgb_hue_split #(
		.HUE_STEPS_PER_DEGREE(HUE_STEPS_PER_DEGREE)
	) u_hue_split (
		.clk            (clk),
		.en             (en[6:1]),
		.base_hue       (base_hue_q),
		.hue_offset     (hsv.hue_offset),
		.saturation_pct (hsv.saturation_pct),
		.value_pct      (hsv.value_pct),
		.rem6_s6        (rem6_s6),
		.a_max_s6       (a_max_s6),
		.a_min_s6       (a_min_s6),
		.a_up_s6        (a_up_s6),
		.a_dn_s6        (a_dn_s6)
	);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			if (rem6_s6 >= REM6_W'(NUM_SECTORS)) begin
				sector_s7 <= sector_t'(rem6_s6 - REM6_W'(NUM_SECTORS));
			end else begin
				sector_s7 <= sector_t'(rem6_s6);
			end
		end
		if (en[8]) begin
			sector_s8 <= sector_s7;
		end
	end

	hsv2rgb_chan_div #(.HUE_STEPS_PER_DEGREE(HUE_STEPS_PER_DEGREE)) u_div_max (
		.clk (clk),
		.en  (en[8:7]),
		.a   (a_max_s6),
		.ch  (ch_max)
	);

	hsv2rgb_chan_div #(.HUE_STEPS_PER_DEGREE(HUE_STEPS_PER_DEGREE)) u_div_min (
		.clk (clk),
		.en  (en[8:7]),
		.a   (a_min_s6),
		.ch  (ch_min)
	);

	hsv2rgb_chan_div #(.HUE_STEPS_PER_DEGREE(HUE_STEPS_PER_DEGREE)) u_div_up (
		.clk (clk),
		.en  (en[8:7]),
		.a   (a_up_s6),
		.ch  (ch_up)
	);

	hsv2rgb_chan_div #(.HUE_STEPS_PER_DEGREE(HUE_STEPS_PER_DEGREE)) u_div_dn (
		.clk (clk),
		.en  (en[8:7]),
		.a   (a_dn_s6),
		.ch  (ch_dn)
	);

	always_ff @(posedge clk) begin
		if (en[9]) begin
			case (sector_s8)
				SEC_RED_YEL: begin
					red_s9   <= ch_max;
					green_s9 <= ch_up;
					blue_s9  <= ch_min;
				end
				SEC_YEL_GRN: begin
					red_s9   <= ch_dn;
					green_s9 <= ch_max;
					blue_s9  <= ch_min;
				end
				SEC_GRN_CYN: begin
					red_s9   <= ch_min;
					green_s9 <= ch_max;
					blue_s9  <= ch_up;
				end
				SEC_CYN_BLU: begin
					red_s9   <= ch_min;
					green_s9 <= ch_dn;
					blue_s9  <= ch_max;
				end
				SEC_BLU_MAG: begin
					red_s9   <= ch_up;
					green_s9 <= ch_min;
					blue_s9  <= ch_max;
				end
				default: begin
					red_s9   <= ch_max;
					green_s9 <= ch_min;
					blue_s9  <= ch_dn;
				end
			endcase
		end
	end

	assign rgb.valid = vld_q[NS];
	assign rgb.red   = red_s9;
	assign rgb.green = green_s9;
	assign rgb.blue  = blue_s9;

endmodule

`default_nettype wire

[rtl/core/hsv2rgb_checker.sv]
// port-level assertions for the converter and their bind to the top level
`default_nettype none

module hsv2rgb_sva import hsv2rgb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              hsv_ready,
	input logic              rgb_valid,
	input logic              rgb_ready,
	input logic [CHAN_W-1:0] red,
	input logic [CHAN_W-1:0] green,
	input logic [CHAN_W-1:0] blue
);

	// a held output beat keeps its payload
	a_rgb_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> rgb_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("rgb beat changed while stalled");

	// input backpressure only when the whole pipe is full behind a stalled output
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!hsv_ready |-> rgb_valid && !rgb_ready)
		else $error("hsv not ready without output stall");

	// an empty output stage always lets input in
	a_ready_open: assert property (@(posedge clk) disable iff (!arst_n)
		!rgb_valid |-> hsv_ready)
		else $error("hsv not ready with empty output");

	// no result right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !rgb_valid)
		else $error("rgb beat right after reset");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_sva u_hsv2rgb_sva (
	.clk       (clk),
	.arst_n    (arst_n),
	.hsv_ready (hsv.ready),
	.rgb_valid (rgb.valid),
	.rgb_ready (rgb.ready),
	.red       (rgb.red),
	.green     (rgb.green),
	.blue      (rgb.blue)
);

`default_nettype wire

[verif/hsv2rgb_checker.sv]
// checker for the hsv to rgb converter: predicts each rgb beat and compares it
module hsv2rgb_checker import hsv2rgb_pkg::*; #(
	parameter int HUE_STEPS_PER_DEGREE = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [HUE_W-1:0] cfg_wdata,
	hsv2rgb_in_if            hsv,
	hsv2rgb_out_if           rgb,
	output int               errors,
	output int               pending,
	output int               beats_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SECTOR_STEPS = SECTOR_DEG * HUE_STEPS_PER_DEGREE;
	localparam longint TURN_STEPS = NUM_SECTORS * SECTOR_STEPS;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_beat_t;

	rgb_beat_t        expected_rgb_q[$];
	logic [HUE_W-1:0] base_hue_copy;

	function automatic longint ramp_level(longint ramp, longint s, longint v);
		longint num;
		num = v * (PCT_FULL - s) * SECTOR_STEPS + ramp * v * s;
		return (CHAN_FULL * num) / (PCT_FULL * PCT_FULL * SECTOR_STEPS);
	endfunction

	function automatic rgb_beat_t convert_hsv(logic [HUE_W-1:0] base,
		logic [HUE_W-1:0] offset, logic [PCT_W-1:0] sat, logic [PCT_W-1:0] val);
		longint s, v, h, f;
		longint top, bottom, rise, fall;
		sector_t sector;
		rgb_beat_t px;
		s = (sat > PCT_FULL) ? PCT_FULL : longint'(sat);
		v = (val > PCT_FULL) ? PCT_FULL : longint'(val);
		h = (longint'(base) + longint'(offset)) % TURN_STEPS;
		sector = sector_t'(h / SECTOR_STEPS);
		f = h % SECTOR_STEPS;
		top = ramp_level(SECTOR_STEPS, s, v);
		bottom = ramp_level(0, s, v);
		rise = ramp_level(f, s, v);
		fall = ramp_level(SECTOR_STEPS - f, s, v);
		case (sector)
			SEC_RED_YEL: px = {8'(top), 8'(rise), 8'(bottom)};
			SEC_YEL_GRN: px = {8'(fall), 8'(top), 8'(bottom)};
			SEC_GRN_CYN: px = {8'(bottom), 8'(top), 8'(rise)};
			SEC_CYN_BLU: px = {8'(bottom), 8'(fall), 8'(top)};
			SEC_BLU_MAG: px = {8'(rise), 8'(bottom), 8'(top)};
			default:     px = {8'(top), 8'(bottom), 8'(fall)};
		endcase
		return px;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic compare_chan(string name, logic [CHAN_W-1:0] got,
		logic [CHAN_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("beat %0d %s got %0d want %0d", beats_checked,
				name, got, want));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rgb_beat_t want;
		if (!arst_n) begin
			base_hue_copy = '0;
			expected_rgb_q.delete();
		end else begin
			if (rgb.valid && rgb.ready) begin
				if (expected_rgb_q.size() == 0) begin
					report_mismatch($sformatf("rgb beat %0d/%0d/%0d with nothing pending",
						rgb.red, rgb.green, rgb.blue));
				end else begin
					want = expected_rgb_q.pop_front();
					compare_chan("red", rgb.red, want.red);
					compare_chan("green", rgb.green, want.green);
					compare_chan("blue", rgb.blue, want.blue);
				end
				beats_checked++;
			end
			if (hsv.valid && hsv.ready) begin
				expected_rgb_q.push_back(convert_hsv(base_hue_copy, hsv.hue_offset,
					hsv.saturation_pct, hsv.value_pct));
			end
			if (cfg_we) begin
				base_hue_copy = cfg_wdata;
			end
		end
		pending = expected_rgb_q.size();
	end
endmodule

[verif/tb_hsv_to_rgb_converter_core.sv]
// testbench top for the hsv to rgb converter: stimulus, output stalls and verdict
module tb_hsv_to_rgb_converter_core;
	import hsv2rgb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS_PER_DEG = 16;
	localparam int HUE_TURN = 360 * STEPS_PER_DEG;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 20;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [HUE_W-1:0] cfg_wdata = '0;

	int errors;
	int pending;
	int beats_checked;
	int beats_sent;
	int base_writes;
	int send_idle;
	int recv_idle;
	int hold_req;
	int hold_ack;
	int cycles;

	hsv2rgb_in_if  hsv_ch();
	hsv2rgb_out_if rgb_ch();

	hsv_to_rgb_converter_core #(
		.HUE_STEPS_PER_DEGREE(STEPS_PER_DEG)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.hsv(hsv_ch),
		.rgb(rgb_ch)
	);

	hsv2rgb_checker #(
		.HUE_STEPS_PER_DEGREE(STEPS_PER_DEG)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.hsv(hsv_ch),
		.rgb(rgb_ch),
		.errors(errors),
		.pending(pending),
		.beats_checked(beats_checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("DONE: errors detected");
		$finish;
	end

	// output side: random stalls, plus a long hold when requested
	initial begin
		rgb_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				rgb_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				rgb_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic send_beat(logic [HUE_W-1:0] offset, logic [PCT_W-1:0] sat,
		logic [PCT_W-1:0] val);
		while ($urandom_range(99) < send_idle) begin
			hsv_ch.valid <= 1'b0;
			@(negedge clk);
		end
		hsv_ch.valid <= 1'b1;
		hsv_ch.hue_offset <= offset;
		hsv_ch.saturation_pct <= sat;
		hsv_ch.value_pct <= val;
		do @(posedge clk); while (!hsv_ch.ready);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic write_base(logic [HUE_W-1:0] value);
		hsv_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		base_writes++;
	endtask

	function automatic logic [PCT_W-1:0] pick_pct();
		case ($urandom_range(9))
			0: return '0;
			1: return PCT_W'(PCT_FULL);
			2: return PCT_W'($urandom_range(PCT_FULL + 1, 127));
			default: return PCT_W'($urandom_range(0, PCT_FULL));
		endcase
	endfunction

	task automatic send_random(int count);
		logic [HUE_W-1:0] offset;
		repeat (count) begin
			if ($urandom_range(9) == 0) begin
				offset = HUE_W'($urandom);
			end else begin
				offset = HUE_W'($urandom_range(0, HUE_TURN - 1));
			end
			send_beat(offset, pick_pct(), pick_pct());
		end
	endtask

	initial begin
		hsv_ch.valid = 1'b0;
		hsv_ch.hue_offset = '0;
		hsv_ch.saturation_pct = '0;
		hsv_ch.value_pct = '0;
		send_idle = 0;
		recv_idle = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: primaries, sector edges, wrap, gray, black, clamping
		write_base('0);
		send_beat(13'd0, 7'd100, 7'd100);
		send_beat(13'd959, 7'd100, 7'd100);
		send_beat(13'd960, 7'd100, 7'd100);
		send_beat(13'd1920, 7'd100, 7'd100);
		send_beat(13'd2880, 7'd100, 7'd100);
		send_beat(13'd3840, 7'd100, 7'd100);
		send_beat(13'd4799, 7'd50, 7'd73);
		send_beat(13'd4800, 7'd50, 7'd73);
		send_beat(13'd5759, 7'd100, 7'd100);
		send_beat(13'd5760, 7'd100, 7'd100);
		send_beat(13'd3000, 7'd0, 7'd50);
		send_beat(13'd1000, 7'd100, 7'd0);
		send_beat(13'd2000, 7'd101, 7'd101);
		send_beat(13'd8191, 7'd127, 7'd127);
		send_beat(13'd8191, 7'd0, 7'd127);
		write_base(13'd5759);
		send_beat(13'd0, 7'd100, 7'd100);
		send_beat(13'd1, 7'd77, 7'd33);
		send_beat(13'd5759, 7'd64, 7'd99);
		send_beat(13'd8191, 7'd127, 7'd1);
		write_base(13'h1fff);
		send_beat(13'd8191, 7'd100, 7'd100);
		send_beat(13'd2431, 7'd37, 7'd88);
		send_beat(13'd0, 7'd127, 7'd0);

		write_base(HUE_W'($urandom_range(0, HUE_TURN - 1)));
		send_idle = 29;
		recv_idle = 49;
		send_random(150);

		write_base(HUE_W'($urandom));
		send_idle = 49;
		recv_idle = 29;
		send_random(150);

		write_base(13'd960);
		send_idle = 0;
		recv_idle = 0;
		send_random(50);
		hold_req++;
		send_random(40);
		send_random(60);

		hsv_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("sent %0d hsv beats, checked %0d rgb beats over %0d base hue writes",
			beats_sent, beats_checked, base_writes);
		$display("idle mixes 29/49, 49/29 and none, one %0d-cycle output hold",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
